// ----- src/rdi_pkg.sv -----
// shared types, widths and register codes for the ray to disk intersection unit
`timescale 1ns / 1ps
package rdi_pkg;
	localparam int DEF_FRAC_BITS = 16;
	localparam int NUM_W = 67;
	localparam int DEN_W = 66;
	localparam int Q_W   = 33;
	localparam int CMP_W = DEN_W + Q_W + 1;
	localparam int SQ_W  = 65;
	localparam int DIST_W = 67;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_NORMAL_X = 3'd3,
		REG_NORMAL_Y = 3'd4,
		REG_NORMAL_Z = 3'd5,
		REG_RADIUS_SQ = 3'd6,
		REG_EPSILON  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][31:0] d;
		logic [2:0][31:0] o;
	} ray_t;

	typedef struct packed {
		logic [2:0][31:0] c;
		logic [2:0][31:0] n;
		logic [30:0]      rs;
		logic [15:0]      eps;
	} cfg_t;

	typedef struct packed {
		logic ok;
		logic neg;
	} div_ctl_t;
endpackage

// ----- src/ray_disk_intersection_unit.sv -----
// top level of the ray to disk intersection unit with configuration registers
// one ray per cycle sustained while the result side accepts
// depth set by the 33 stage restoring divider, one quotient bit per stage
// a stall on the result side holds the whole pipeline, no bubble squeezing
// arst_n clears all valid bits and loads the disk registers with their defaults
`timescale 1ns / 1ps
module ray_disk_intersection_unit #(
	parameter int FRAC_BITS = rdi_pkg::DEF_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // hit_distance, hit_point_x, hit_point_y, hit_point_z
	output logic         m_tuser,  // is_hit
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);
	rdi_pkg::cfg_t cfg_q;
	rdi_pkg::ray_t in_ray, dot_ray, div_ray;
	logic          en;
	logic          dot_valid, div_valid, div_ok;
	logic signed [rdi_pkg::NUM_W-1:0] num;
	logic signed [rdi_pkg::DEN_W-1:0] den;
	logic [31:0]   div_t;
	logic          hit;
	logic [31:0]   dist_t;
	logic [2:0][31:0] pt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{c: '0, n: {32'd0, 32'(1) << FRAC_BITS, 32'd0},
				rs: 31'(1) << FRAC_BITS, eps: 16'd1};
		end else if (cfg_we) begin
			case (rdi_pkg::reg_idx_t'(cfg_index))
				rdi_pkg::REG_CENTER_X:  cfg_q.c[0] <= cfg_wdata;
				rdi_pkg::REG_CENTER_Y:  cfg_q.c[1] <= cfg_wdata;
				rdi_pkg::REG_CENTER_Z:  cfg_q.c[2] <= cfg_wdata;
				rdi_pkg::REG_NORMAL_X:  cfg_q.n[0] <= cfg_wdata;
				rdi_pkg::REG_NORMAL_Y:  cfg_q.n[1] <= cfg_wdata;
				rdi_pkg::REG_NORMAL_Z:  cfg_q.n[2] <= cfg_wdata;
				rdi_pkg::REG_RADIUS_SQ: cfg_q.rs   <= cfg_wdata[30:0];
				rdi_pkg::REG_EPSILON:   cfg_q.eps  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_ray.o[i] = s_tdata[32*i +: 32];
			in_ray.d[i] = s_tdata[96 + 32*i +: 32];
		end
	end

	rdi_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_ray    (in_ray),
		.cfg       (cfg_q),
		.out_valid (dot_valid),
		.out_ray   (dot_ray),
		.num       (num),
		.den       (den)
	);

	rdi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dot_valid),
		.in_ray    (dot_ray),
		.num       (num),
		.den       (den),
		.eps       (cfg_q.eps),
		.out_valid (div_valid),
		.out_ray   (div_ray),
		.out_ok    (div_ok),
		.out_t     (div_t)
	);

	rdi_point #(.FRAC_BITS(FRAC_BITS)) u_point (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (div_valid),
		.in_ray       (div_ray),
		.in_ok        (div_ok),
		.in_t         (div_t),
		.cfg          (cfg_q),
		.out_valid    (m_tvalid),
		.is_hit       (hit),
		.hit_distance (dist_t),
		.hit_point    (pt)
	);

	assign m_tuser = hit;
	assign m_tdata = {pt[2], pt[1], pt[0], dist_t};

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss result carries data");

	a_hit_positive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[31] && m_tdata[31:0] != '0)
		else $error("hit with non-positive distance");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output empty");
endmodule

// ----- src/rdi_dot.sv -----
// three stage dot products for numerator and denominator of the ray distance
`timescale 1ns / 1ps
module rdi_dot (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  rdi_pkg::ray_t               in_ray,
	input  rdi_pkg::cfg_t               cfg,
	output logic                        out_valid,
	output rdi_pkg::ray_t               out_ray,
	output logic signed [rdi_pkg::NUM_W-1:0] num,
	output logic signed [rdi_pkg::DEN_W-1:0] den
);
	logic                v_s1, v_s2, v_s3;
	rdi_pkg::ray_t       ray_s1, ray_s2, ray_s3;
	logic signed [32:0]  diff_s1 [3];
	logic signed [64:0]  pn_s2 [3];
	logic signed [63:0]  pd_s2 [3];
	logic signed [rdi_pkg::NUM_W-1:0] num_s3;
	logic signed [rdi_pkg::DEN_W-1:0] den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= in_ray;
			ray_s2 <= ray_s1;
			ray_s3 <= ray_s2;
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= 33'($signed(cfg.c[i])) - 33'($signed(in_ray.o[i]));
				pn_s2[i] <= diff_s1[i] * $signed(cfg.n[i]);
				pd_s2[i] <= $signed(ray_s1.d[i]) * $signed(cfg.n[i]);
			end
			num_s3 <= rdi_pkg::NUM_W'(pn_s2[0]) + rdi_pkg::NUM_W'(pn_s2[1])
				+ rdi_pkg::NUM_W'(pn_s2[2]);
			den_s3 <= rdi_pkg::DEN_W'(pd_s2[0]) + rdi_pkg::DEN_W'(pd_s2[1])
				+ rdi_pkg::DEN_W'(pd_s2[2]);
		end
	end

	assign out_valid = v_s3;
	assign out_ray   = ray_s3;
	assign num       = num_s3;
	assign den       = den_s3;
endmodule

// ----- src/rdi_div_stage.sv -----
// one restoring division stage producing a single quotient bit
`timescale 1ns / 1ps
module rdi_div_stage #(
	parameter int RW    = 83,
	parameter int SHIFT = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  rdi_pkg::div_ctl_t             in_ctl,
	input  rdi_pkg::ray_t                 in_ray,
	input  logic [RW-1:0]                 in_rem,
	input  logic [rdi_pkg::DEN_W-1:0]     in_md,
	input  logic [rdi_pkg::Q_W-1:0]       in_q,
	output logic                          out_valid,
	output rdi_pkg::div_ctl_t             out_ctl,
	output rdi_pkg::ray_t                 out_ray,
	output logic [RW-1:0]                 out_rem,
	output logic [rdi_pkg::DEN_W-1:0]     out_md,
	output logic [rdi_pkg::Q_W-1:0]       out_q
);
	logic [rdi_pkg::CMP_W-1:0] rem_w, sub_w, dif_w;
	logic                      ge;
	logic                      v_s1;
	rdi_pkg::div_ctl_t         ctl_s1;
	rdi_pkg::ray_t             ray_s1;
	logic [RW-1:0]             rem_s1;
	logic [rdi_pkg::DEN_W-1:0] md_s1;
	logic [rdi_pkg::Q_W-1:0]   q_s1;

	always_comb begin
		rem_w = rdi_pkg::CMP_W'(in_rem);
		sub_w = rdi_pkg::CMP_W'(in_md) << SHIFT;
		ge    = rem_w >= sub_w;
		dif_w = rem_w - sub_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= in_ctl;
			ray_s1 <= in_ray;
			md_s1  <= in_md;
			rem_s1 <= ge ? dif_w[RW-1:0] : in_rem;
			q_s1   <= in_q | (rdi_pkg::Q_W'(ge) << SHIFT);
		end
	end

	assign out_valid = v_s1;
	assign out_ctl   = ctl_s1;
	assign out_ray   = ray_s1;
	assign out_rem   = rem_s1;
	assign out_md    = md_s1;
	assign out_q     = q_s1;
endmodule

// ----- src/rdi_div.sv -----
// pipelined signed division giving the ray distance with range and epsilon checks
`timescale 1ns / 1ps
module rdi_div #(
	parameter int FRAC_BITS = rdi_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  rdi_pkg::ray_t                    in_ray,
	input  logic signed [rdi_pkg::NUM_W-1:0] num,
	input  logic signed [rdi_pkg::DEN_W-1:0] den,
	input  logic [15:0]                      eps,
	output logic                             out_valid,
	output rdi_pkg::ray_t                    out_ray,
	output logic                             out_ok,
	output logic [31:0]                      out_t
);
	localparam int RW = rdi_pkg::NUM_W + FRAC_BITS;
	localparam int NST = rdi_pkg::Q_W;

	logic                      v_s1, v_s2, v_f;
	rdi_pkg::div_ctl_t         ctl_s1, ctl_s2;
	rdi_pkg::ray_t             ray_s1, ray_s2, ray_f;
	logic [RW-1:0]             mn_s1, mn_s2;
	logic [rdi_pkg::DEN_W-1:0] md_s1, md_s2;
	logic [rdi_pkg::NUM_W-1:0] num_mag;
	logic [rdi_pkg::DEN_W-1:0] den_mag;
	logic                      ovf;
	logic                      ok_f;
	logic [31:0]               t_f;

	logic                      cv   [NST+1];
	rdi_pkg::div_ctl_t         cctl [NST+1];
	rdi_pkg::ray_t             cray [NST+1];
	logic [RW-1:0]             crem [NST+1];
	logic [rdi_pkg::DEN_W-1:0] cmd  [NST+1];
	logic [rdi_pkg::Q_W-1:0]   cq   [NST+1];

	logic [rdi_pkg::Q_W-1:0]   qf;
	logic                      qbig;
	logic [31:0]               tv;

	always_comb begin
		num_mag = num[rdi_pkg::NUM_W-1] ? rdi_pkg::NUM_W'(-num) : rdi_pkg::NUM_W'(num);
		den_mag = den[rdi_pkg::DEN_W-1] ? rdi_pkg::DEN_W'(-den) : rdi_pkg::DEN_W'(den);
		ovf = rdi_pkg::CMP_W'(mn_s1) >= (rdi_pkg::CMP_W'(md_s1) << rdi_pkg::Q_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_f  <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_f  <= cv[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1     <= '{ok: den != '0,
				neg: num[rdi_pkg::NUM_W-1] ^ den[rdi_pkg::DEN_W-1]};
			ray_s1     <= in_ray;
			mn_s1      <= RW'(num_mag) << FRAC_BITS;
			md_s1      <= den_mag;
			ctl_s2     <= '{ok: ctl_s1.ok && !ovf, neg: ctl_s1.neg};
			ray_s2     <= ray_s1;
			mn_s2      <= mn_s1;
			md_s2      <= md_s1;
			ray_f      <= cray[NST];
			ok_f       <= cctl[NST].ok && !qbig
				&& ($signed(33'($signed(tv))) > $signed({17'd0, eps}));
			t_f        <= tv;
		end
	end

	assign cv[0]   = v_s2;
	assign cctl[0] = ctl_s2;
	assign cray[0] = ray_s2;
	assign crem[0] = mn_s2;
	assign cmd[0]  = md_s2;
	assign cq[0]   = '0;

	for (genvar k = 0; k < NST; k++) begin : g_div
		rdi_div_stage #(
			.RW    (RW),
			.SHIFT (NST - 1 - k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cv[k]),
			.in_ctl    (cctl[k]),
			.in_ray    (cray[k]),
			.in_rem    (crem[k]),
			.in_md     (cmd[k]),
			.in_q      (cq[k]),
			.out_valid (cv[k+1]),
			.out_ctl   (cctl[k+1]),
			.out_ray   (cray[k+1]),
			.out_rem   (crem[k+1]),
			.out_md    (cmd[k+1]),
			.out_q     (cq[k+1])
		);
	end

	always_comb begin
		qf   = cq[NST];
		qbig = cctl[NST].neg ? (qf > 33'h080000000) : (qf > 33'h07fffffff);
		tv   = cctl[NST].neg ? (~qf[31:0] + 32'd1) : qf[31:0];
	end

	assign out_valid = v_f;
	assign out_ray   = ray_f;
	assign out_ok    = ok_f;
	assign out_t     = t_f;
endmodule

// ----- src/rdi_point.sv -----
// hit point, squared distance to the centre and final result register
`timescale 1ns / 1ps
module rdi_point #(
	parameter int FRAC_BITS = rdi_pkg::DEF_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  rdi_pkg::ray_t in_ray,
	input  logic          in_ok,
	input  logic [31:0]   in_t,
	input  rdi_pkg::cfg_t cfg,
	output logic          out_valid,
	output logic          is_hit,
	output logic [31:0]   hit_distance,
	output logic [2:0][31:0] hit_point
);
	localparam int LIM_W = 31 + FRAC_BITS;

	logic                 v_a, v_b, v_c, v_d;
	logic                 ok_a, ok_b, ok_c;
	logic [31:0]          t_a, t_b, t_c;
	rdi_pkg::ray_t        ray_a;
	logic signed [63:0]   prod_a [3];
	logic [2:0][31:0]     p_b, p_c;
	logic [2:0][31:0]     p_w;
	logic signed [32:0]   pc_b [3];
	logic [rdi_pkg::SQ_W-1:0] sq_c [3];
	logic signed [63:0]   sh [3];
	logic signed [64:0]   pw [3];
	logic [2:0]           rng;
	logic signed [65:0]   sqw [3];
	logic [rdi_pkg::DIST_W-1:0] dsq;
	logic [LIM_W-1:0]     lim;
	logic                 hit_d;
	logic [31:0]          t_d;
	logic [2:0][31:0]     p_d;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i]  = prod_a[i] >>> FRAC_BITS;
			pw[i]  = 65'(sh[i]) + 65'($signed(ray_a.o[i]));
			p_w[i] = pw[i][31:0];
			rng[i] = (pw[i][64:31] == '0) || (pw[i][64:31] == '1);
			sqw[i] = pc_b[i] * pc_b[i];
		end
		dsq = rdi_pkg::DIST_W'(sq_c[0]) + rdi_pkg::DIST_W'(sq_c[1])
			+ rdi_pkg::DIST_W'(sq_c[2]);
		lim = LIM_W'(cfg.rs) << FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
			v_b <= 1'b0;
			v_c <= 1'b0;
			v_d <= 1'b0;
		end else if (en) begin
			v_a <= in_valid;
			v_b <= v_a;
			v_c <= v_b;
			v_d <= v_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_a  <= in_ok;
			t_a   <= in_t;
			ray_a <= in_ray;
			for (int i = 0; i < 3; i++) begin
				prod_a[i] <= $signed(in_t) * $signed(in_ray.d[i]);
				pc_b[i]   <= 33'($signed(pw[i][31:0])) - 33'($signed(cfg.c[i]));
				sq_c[i]   <= sqw[i][rdi_pkg::SQ_W-1:0];
			end
			p_b   <= p_w;
			ok_b  <= ok_a && (&rng);
			t_b   <= t_a;
			ok_c  <= ok_b;
			t_c   <= t_b;
			p_c   <= p_b;
			hit_d <= ok_c && (dsq < rdi_pkg::DIST_W'(lim));
			t_d   <= (ok_c && (dsq < rdi_pkg::DIST_W'(lim))) ? t_c : '0;
			p_d   <= (ok_c && (dsq < rdi_pkg::DIST_W'(lim))) ? p_c : '0;
		end
	end

	assign out_valid    = v_d;
	assign is_hit       = hit_d;
	assign hit_distance = t_d;
	assign hit_point    = p_d;
endmodule
